FILE: design/go_to_goal_steering_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// go_to_goal_steering_controller_unit_macros
// assertion macros shared by the go-to-goal steering controller
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_STEERING_CONTROLLER_UNIT_MACROS_SVH
`define GO_TO_GOAL_STEERING_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define GGSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define GGSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ggsc_pkg.sv
// ----------------------------------------------------------------------------
// ggsc_pkg
// widths, codes, microcode word layout and tables of the steering controller
// ----------------------------------------------------------------------------
package ggsc_pkg;

  // arithmetic configuration
  localparam int CORDIC_ITERATIONS = 16;
  localparam int FRACTION_BITS     = 12;

  // field widths
  localparam int OP_W       = 2;
  localparam int POS_W      = 16;
  localparam int HEAD_W     = 15;
  localparam int GAIN_W     = 8;
  localparam int GAIN_FRAC  = 4;
  localparam int LIN_W      = 18;
  localparam int TURN_W     = 18;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int S_TDATA_W = ((2 * POS_W + HEAD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((LIN_W + TURN_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - LIN_W - TURN_W;

  // operation codes (tuser)
  localparam logic [OP_W-1:0] OP_POSE   = 2'd0;
  localparam logic [OP_W-1:0] OP_TARGET = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_GAIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA     = 4'd3;

  localparam logic [POS_W-1:0]  TOLERANCE_RST = 16'd2048;
  localparam logic [GAIN_W-1:0] LIN_GAIN_RST  = 8'd32;
  localparam logic [GAIN_W-1:0] ANG_GAIN_RST  = 8'd96;
  localparam logic [POS_W-1:0]  ARENA_RST     = 16'd45056;

  // datapath widths
  localparam int DELTA_W     = POS_W + 1;
  localparam int SQRT_STEPS  = POS_W + 1;
  localparam int SQ_W        = 2 * POS_W + 3;
  localparam int SQRT_TOP    = 2 * (SQRT_STEPS - 1);
  localparam int DIST_W      = POS_W + 1;
  localparam int PRE_SHIFT   = 14;
  localparam int CORDIC_W    = DELTA_W + PRE_SHIFT + 5;
  localparam int ANGLE_Q     = 30;
  localparam int Z_W         = ANGLE_Q + 4;
  localparam int ATAN_LEN    = 24;
  localparam int ROUND_SHIFT = ANGLE_Q - FRACTION_BITS;
  localparam int ZR_W        = Z_W - ROUND_SHIFT;
  localparam int ERR_W       = ((ZR_W > HEAD_W) ? ZR_W : HEAD_W) + 2;
  localparam int MUL_W       = (ERR_W > DELTA_W + 1) ? ERR_W : DELTA_W + 1;
  localparam int PROD_W      = 2 * MUL_W;

  localparam int LOOP_LAST = ((CORDIC_ITERATIONS > SQRT_STEPS) ?
                              CORDIC_ITERATIONS : SQRT_STEPS) - 1;
  localparam int CNT_W     = $clog2(LOOP_LAST + 1);

  localparam logic [CNT_W-1:0] LOOP_LAST_CNT   = CNT_W'(LOOP_LAST);
  localparam logic [CNT_W-1:0] CORDIC_LAST_CNT = CNT_W'(CORDIC_ITERATIONS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST_CNT   = CNT_W'(SQRT_STEPS - 1);

  localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(64'd1 << SQRT_TOP);

  // angle constants
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint PI_QF  = (PI_Q30 + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
  localparam logic signed [Z_W-1:0]   PI_Z       = Z_W'(PI_Q30);
  localparam logic signed [Z_W-1:0]   ROUND_HALF = Z_W'(longint'(1) <<< (ROUND_SHIFT - 1));
  localparam logic signed [ERR_W-1:0] PI_ERR     = ERR_W'(PI_QF);
  localparam logic signed [ERR_W-1:0] NEG_PI_ERR = ERR_W'(-PI_QF);
  localparam logic signed [ERR_W-1:0] TWO_PI_ERR = ERR_W'(2 * PI_QF);

  // output saturation bounds at product width
  localparam logic signed [PROD_W-1:0] LIN_MAX_P  = PROD_W'((longint'(1) <<< LIN_W) - 1);
  localparam logic signed [PROD_W-1:0] TURN_MAX_P =
    PROD_W'((longint'(1) <<< (TURN_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] TURN_MIN_P = PROD_W'(-(longint'(1) <<< (TURN_W - 1)));
  localparam logic [LIN_W-1:0]         LIN_MAX    = {LIN_W{1'b1}};
  localparam logic signed [TURN_W-1:0] TURN_MAX   = {1'b0, {(TURN_W - 1){1'b1}}};
  localparam logic signed [TURN_W-1:0] TURN_MIN   = {1'b1, {(TURN_W - 1){1'b0}}};

  // datapath operations
  localparam int DP_OP_W = 4;
  localparam logic [DP_OP_W-1:0] DP_IDLE  = 4'd0;
  localparam logic [DP_OP_W-1:0] DP_DELTA = 4'd1;
  localparam logic [DP_OP_W-1:0] DP_SQX   = 4'd2;
  localparam logic [DP_OP_W-1:0] DP_SQY   = 4'd3;
  localparam logic [DP_OP_W-1:0] DP_LOOP  = 4'd4;
  localparam logic [DP_OP_W-1:0] DP_CHECK = 4'd5;
  localparam logic [DP_OP_W-1:0] DP_WRAP  = 4'd6;
  localparam logic [DP_OP_W-1:0] DP_LIN   = 4'd7;
  localparam logic [DP_OP_W-1:0] DP_TURN  = 4'd8;
  localparam logic [DP_OP_W-1:0] DP_ZERO  = 4'd9;
  localparam logic [DP_OP_W-1:0] DP_OUT   = 4'd10;

  // jump conditions
  localparam int JC_W = 3;
  localparam logic [JC_W-1:0] JC_NEXT     = 3'd0;
  localparam logic [JC_W-1:0] JC_START    = 3'd1;
  localparam logic [JC_W-1:0] JC_LOOP     = 3'd2;
  localparam logic [JC_W-1:0] JC_REACHED  = 3'd3;
  localparam logic [JC_W-1:0] JC_ALWAYS   = 3'd4;
  localparam logic [JC_W-1:0] JC_OUT_FREE = 3'd5;

  // program steps
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] STEP_DELTA = 4'd1;
  localparam logic [PC_W-1:0] STEP_SQX   = 4'd2;
  localparam logic [PC_W-1:0] STEP_SQY   = 4'd3;
  localparam logic [PC_W-1:0] STEP_LOOP  = 4'd4;
  localparam logic [PC_W-1:0] STEP_CHECK = 4'd5;
  localparam logic [PC_W-1:0] STEP_WRAP  = 4'd6;
  localparam logic [PC_W-1:0] STEP_LIN   = 4'd7;
  localparam logic [PC_W-1:0] STEP_TURN  = 4'd8;
  localparam logic [PC_W-1:0] STEP_ZERO  = 4'd9;
  localparam logic [PC_W-1:0] STEP_OUT   = 4'd10;

  typedef struct packed {
    logic [DP_OP_W-1:0] dp_op;
    logic [JC_W-1:0]    jump;
    logic [PC_W-1:0]    target;
  } ucode_word_t;

  typedef struct packed {
    logic [DP_OP_W-1:0] dp_op;
    logic [CNT_W-1:0]   loop_cnt;
    logic               idle;
    logic               out_load;
  } seq_ctrl_t;

  typedef struct packed {
    logic start;
    logic reached;
  } dp_status_t;

  typedef struct packed {
    logic [POS_W-1:0]  tolerance;
    logic [GAIN_W-1:0] lin_gain;
    logic [GAIN_W-1:0] ang_gain;
    logic [POS_W-1:0]  arena;
  } cfg_regs_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [CNT_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return $signed(Z_W'(v));
  endfunction

endpackage

FILE: design/ggsc_ucode_rom.sv
// ----------------------------------------------------------------------------
// ggsc_ucode_rom
// control store: one microcode word per program step
// ----------------------------------------------------------------------------
module ggsc_ucode_rom (
  input  logic [ggsc_pkg::PC_W-1:0] pc,
  output ggsc_pkg::ucode_word_t     word
);
  import ggsc_pkg::*;

  always_comb begin
    unique case (pc)
      STEP_IDLE:  word = '{dp_op: DP_IDLE,  jump: JC_START,    target: STEP_DELTA};
      STEP_DELTA: word = '{dp_op: DP_DELTA, jump: JC_NEXT,     target: STEP_IDLE};
      STEP_SQX:   word = '{dp_op: DP_SQX,   jump: JC_NEXT,     target: STEP_IDLE};
      STEP_SQY:   word = '{dp_op: DP_SQY,   jump: JC_NEXT,     target: STEP_IDLE};
      STEP_LOOP:  word = '{dp_op: DP_LOOP,  jump: JC_LOOP,     target: STEP_LOOP};
      STEP_CHECK: word = '{dp_op: DP_CHECK, jump: JC_REACHED,  target: STEP_ZERO};
      STEP_WRAP:  word = '{dp_op: DP_WRAP,  jump: JC_NEXT,     target: STEP_IDLE};
      STEP_LIN:   word = '{dp_op: DP_LIN,   jump: JC_NEXT,     target: STEP_IDLE};
      STEP_TURN:  word = '{dp_op: DP_TURN,  jump: JC_ALWAYS,   target: STEP_OUT};
      STEP_ZERO:  word = '{dp_op: DP_ZERO,  jump: JC_NEXT,     target: STEP_IDLE};
      STEP_OUT:   word = '{dp_op: DP_OUT,   jump: JC_OUT_FREE, target: STEP_IDLE};
      default:    word = '{dp_op: DP_IDLE,  jump: JC_ALWAYS,   target: STEP_IDLE};
    endcase
  end

endmodule

FILE: design/ggsc_sequencer.sv
// ----------------------------------------------------------------------------
// ggsc_sequencer
// step counter, loop counter and jump logic over the control store
// ----------------------------------------------------------------------------
module ggsc_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  ggsc_pkg::dp_status_t  dp_status,
  input  logic                  out_free,
  output ggsc_pkg::seq_ctrl_t   seq_ctrl
);
  import ggsc_pkg::*;

  logic [PC_W-1:0]  pc, pc_next;
  logic [CNT_W-1:0] loop_cnt, loop_cnt_next;
  ucode_word_t      word;

  ggsc_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  always_comb begin
    pc_next       = pc + PC_W'(1);
    loop_cnt_next = loop_cnt;
    unique case (word.jump)
      JC_NEXT: begin
      end
      JC_START: begin
        if (!dp_status.start) pc_next = pc;
      end
      JC_LOOP: begin
        if (loop_cnt != LOOP_LAST_CNT) begin
          pc_next       = word.target;
          loop_cnt_next = loop_cnt + CNT_W'(1);
        end else begin
          loop_cnt_next = '0;
        end
      end
      JC_REACHED: begin
        if (dp_status.reached) pc_next = word.target;
      end
      JC_ALWAYS: begin
        pc_next = word.target;
      end
      JC_OUT_FREE: begin
        pc_next = out_free ? word.target : pc;
      end
      default: begin
        pc_next = STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= STEP_IDLE;
      loop_cnt <= '0;
    end else begin
      pc       <= pc_next;
      loop_cnt <= loop_cnt_next;
    end
  end

  assign seq_ctrl.dp_op    = word.dp_op;
  assign seq_ctrl.loop_cnt = loop_cnt;
  assign seq_ctrl.idle     = (word.dp_op == DP_IDLE);
  assign seq_ctrl.out_load = (word.jump == JC_OUT_FREE) && out_free;

endmodule

FILE: design/ggsc_datapath.sv
// ----------------------------------------------------------------------------
// ggsc_datapath
// pose and target state, shared multiplier, bit-serial square root,
// cordic vectoring unit and output shaping
// ----------------------------------------------------------------------------
module ggsc_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  ggsc_pkg::seq_ctrl_t                seq_ctrl,
  input  ggsc_pkg::cfg_regs_t                cfg,
  input  logic                               in_accept,
  input  logic [ggsc_pkg::OP_W-1:0]          in_op,
  input  logic [ggsc_pkg::POS_W-1:0]         in_x,
  input  logic [ggsc_pkg::POS_W-1:0]         in_y,
  input  logic signed [ggsc_pkg::HEAD_W-1:0] in_heading,
  output ggsc_pkg::dp_status_t               dp_status,
  output logic [ggsc_pkg::LIN_W-1:0]         lin_speed,
  output logic signed [ggsc_pkg::TURN_W-1:0] turn_rate
);
  import ggsc_pkg::*;

  logic [POS_W-1:0]         pose_x, pose_y, target_x, target_y;
  logic signed [HEAD_W-1:0] pose_heading;
  logic                     pose_seen, target_seen;

  logic signed [DELTA_W-1:0]  dx, dy;
  logic [SQ_W-1:0]            acc, sq_rem, sq_res, sq_bit;
  logic signed [CORDIC_W-1:0] cx, cy;
  logic signed [Z_W-1:0]      cz;
  logic signed [ERR_W-1:0]    err;
  logic [LIN_W-1:0]           lin;
  logic signed [TURN_W-1:0]   turn;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p, prod_shift;
  logic [SQ_W-1:0]            sq_trial;
  logic signed [CORDIC_W-1:0] x0, y0, xs, ys;
  logic signed [Z_W-1:0]      z_round, atan_step;
  logic [DIST_W-1:0]          distance;
  logic                       target_ok;

  assign distance  = sq_res[DIST_W-1:0];
  assign target_ok = (in_x != '0) && (in_x < cfg.arena) &&
                     (in_y != '0) && (in_y < cfg.arena);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (seq_ctrl.dp_op)
      DP_SQX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      DP_SQY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      DP_LIN: begin
        mul_a = $signed(MUL_W'(cfg.lin_gain));
        mul_b = $signed(MUL_W'(distance));
      end
      DP_TURN: begin
        mul_a = $signed(MUL_W'(cfg.ang_gain));
        mul_b = MUL_W'(err);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mul_p      = mul_a * mul_b;
    prod_shift = mul_p >>> GAIN_FRAC;
    sq_trial   = sq_res + sq_bit;
    x0         = CORDIC_W'(dx) <<< PRE_SHIFT;
    y0         = CORDIC_W'(dy) <<< PRE_SHIFT;
    xs         = cx >>> seq_ctrl.loop_cnt;
    ys         = cy >>> seq_ctrl.loop_cnt;
    atan_step  = atan_q30(seq_ctrl.loop_cnt);
    z_round    = (cz + ROUND_HALF) >>> ROUND_SHIFT;
  end

  assign dp_status.start   = in_accept && (in_op == OP_TICK) && pose_seen && target_seen;
  assign dp_status.reached = (distance <= DIST_W'(cfg.tolerance));

  // stored pose and target
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      target_x     <= '0;
      target_y     <= '0;
      pose_seen    <= 1'b0;
      target_seen  <= 1'b0;
    end else if (in_accept) begin
      case (in_op)
        OP_POSE: begin
          pose_x       <= in_x;
          pose_y       <= in_y;
          pose_heading <= in_heading;
          pose_seen    <= 1'b1;
        end
        OP_TARGET: begin
          if (target_ok) begin
            target_x    <= in_x;
            target_y    <= in_y;
            target_seen <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers driven by the current control word
  always_ff @(posedge clk) begin
    case (seq_ctrl.dp_op)
      DP_DELTA: begin
        dx <= $signed({1'b0, target_x}) - $signed({1'b0, pose_x});
        dy <= $signed({1'b0, target_y}) - $signed({1'b0, pose_y});
      end
      DP_SQX: begin
        acc <= SQ_W'($unsigned(mul_p));
        // left half-plane: rotate by pi first
        if (dx < 0) begin
          cx <= -x0;
          cy <= -y0;
          cz <= (dy >= 0) ? PI_Z : -PI_Z;
        end else begin
          cx <= x0;
          cy <= y0;
          cz <= '0;
        end
      end
      DP_SQY: begin
        sq_rem <= acc + SQ_W'($unsigned(mul_p));
        sq_res <= '0;
        sq_bit <= SQ_BIT0;
      end
      DP_LOOP: begin
        if (seq_ctrl.loop_cnt <= SQRT_LAST_CNT) begin
          if (sq_rem >= sq_trial) begin
            sq_rem <= sq_rem - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        if (seq_ctrl.loop_cnt <= CORDIC_LAST_CNT) begin
          if (!cy[CORDIC_W-1]) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_step;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_step;
          end
        end
      end
      DP_CHECK: begin
        err <= ERR_W'(z_round) - ERR_W'(pose_heading);
      end
      DP_WRAP: begin
        if (err > PI_ERR) begin
          err <= err - TWO_PI_ERR;
        end else if (err < NEG_PI_ERR) begin
          err <= err + TWO_PI_ERR;
        end
      end
      DP_LIN: begin
        lin <= (prod_shift > LIN_MAX_P) ? LIN_MAX : LIN_W'(prod_shift);
      end
      DP_TURN: begin
        if (prod_shift > TURN_MAX_P) begin
          turn <= TURN_MAX;
        end else if (prod_shift < TURN_MIN_P) begin
          turn <= TURN_MIN;
        end else begin
          turn <= TURN_W'(prod_shift);
        end
      end
      DP_ZERO: begin
        lin  <= '0;
        turn <= '0;
      end
      default: begin
      end
    endcase
  end

  assign lin_speed = lin;
  assign turn_rate = turn;

endmodule

FILE: design/go_to_goal_steering_controller_unit.sv
// ----------------------------------------------------------------------------
// go_to_goal_steering_controller_unit
// proportional go-to-goal steering controller, microcoded datapath
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one transfer per command; tuser selects pose update, target
//     update or control tick, tdata carries x, y and heading
//   m_* channel: one transfer per control tick once a pose and a target have
//     been stored: forward speed and turn rate
//   cfg_* channel: register writes (tolerance, gains, arena limit), always
//     ready, meant to be used while the controller is idle
// throughput and program flow
//   pose and target updates are stored from the idle step, and back-to-back
//     transfers are taken at full rate
//   a tick runs the microprogram: 3 setup steps, 17 loop steps (square root
//     one bit a step, cordic one rotation a step, in the same loop), then
//     4 steps of error, wrap and gain multiply (error and an output-zeroing
//     step when the target counts as reached); the output step sets m_tvalid
//   the input stays not ready while the program runs, so the next command waits
//     until the program, chiefly its sqrt and cordic loop, is back at idle
// reset
//   rst is synchronous: step counter back to idle, pose and target forgotten,
//     registers to their defaults, output register empty
// stall
//   the result sits in an output register; with m_tready low the controller
//     still takes pose and target updates, and a following tick computes and
//     waits at its last step until the register frees
// ----------------------------------------------------------------------------
`include "go_to_goal_steering_controller_unit_macros.svh"

module go_to_goal_steering_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  // command in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // position_x [15:0], position_y [31:16], heading [46:32], zero pad [47]
  input  logic [ggsc_pkg::S_TDATA_W-1:0]      s_tdata,
  // operation [1:0]
  input  logic [ggsc_pkg::OP_W-1:0]           s_tuser,
  // result out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // linear_speed [17:0], turn_rate [35:18], zero pad [39:36]
  output logic [ggsc_pkg::M_TDATA_W-1:0]      m_tdata,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ggsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ggsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ggsc_pkg::*;

  seq_ctrl_t  seq_ctrl;
  dp_status_t dp_status;
  cfg_regs_t  cfg;

  logic                     in_accept;
  logic                     out_free;
  logic                     out_valid;
  logic [LIN_W-1:0]         out_lin;
  logic signed [TURN_W-1:0] out_turn;
  logic [LIN_W-1:0]         lin_speed;
  logic signed [TURN_W-1:0] turn_rate;

  // input is taken only while the program sits at its idle step
  assign s_tready  = seq_ctrl.idle;
  assign in_accept = s_tvalid && s_tready;

  // output register is free when empty or being drained this cycle
  assign out_free  = !out_valid || m_tready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance <= TOLERANCE_RST;
      cfg.lin_gain  <= LIN_GAIN_RST;
      cfg.ang_gain  <= ANG_GAIN_RST;
      cfg.arena     <= ARENA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOLERANCE: cfg.tolerance <= cfg_data[POS_W-1:0];
        CFG_LIN_GAIN:  cfg.lin_gain  <= cfg_data[GAIN_W-1:0];
        CFG_ANG_GAIN:  cfg.ang_gain  <= cfg_data[GAIN_W-1:0];
        CFG_ARENA:     cfg.arena     <= cfg_data[POS_W-1:0];
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  ggsc_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .dp_status (dp_status),
    .out_free  (out_free),
    .seq_ctrl  (seq_ctrl)
  );

  ggsc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .seq_ctrl   (seq_ctrl),
    .cfg        (cfg),
    .in_accept  (in_accept),
    .in_op      (s_tuser),
    .in_x       (s_tdata[POS_W-1:0]),
    .in_y       (s_tdata[2*POS_W-1:POS_W]),
    .in_heading ($signed(s_tdata[2*POS_W+HEAD_W-1:2*POS_W])),
    .dp_status  (dp_status),
    .lin_speed  (lin_speed),
    .turn_rate  (turn_rate)
  );

  // output register, loaded at the last program step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_ctrl.out_load) begin
      out_lin  <= lin_speed;
      out_turn <= turn_rate;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{M_PAD_W{1'b0}}, out_turn, out_lin};

  // a result never overwrites one still waiting for its transfer
  `GGSC_ASSERT_IMP(a_load_into_free_slot, seq_ctrl.out_load, !out_valid || m_tready,
                   "result loaded over a pending transfer")
  // a qualifying tick leaves the idle step on the next cycle
  `GGSC_ASSERT_NXT(a_tick_starts_program, dp_status.start, !seq_ctrl.idle,
                   "tick accepted but program did not start")
  // valid only rises from a load by the last program step
  `GGSC_ASSERT_IMP(a_valid_from_load, $rose(out_valid), $past(seq_ctrl.out_load),
                   "output valid rose without a program load")

endmodule
